// ----- src/spd_pkg.sv -----
package spd_pkg;

  // The distance field is a fixed 33-bit unsigned value.
  localparam int OUT_BITS = 33;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- src/spd_root.sv -----
module spd_root
  import spd_pkg::*;
#(
  parameter int NUM_W     = 68,
  parameter int DEN_W     = 34,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output logic [OUT_BITS-1:0] root_o
);

  localparam int RW = NUM_W + 2 * FRAC_BITS;
  localparam int TW = max_int(RW, 2 * OUT_BITS + DEN_W) + 1;
  localparam int QW = OUT_BITS + DEN_W;

  // Per stage: p = r*r*den, q = r*den, the partial root r, den and the scaled numerator.
  logic [TW-1:0]       p_r [OUT_BITS];
  logic [QW-1:0]       q_r [OUT_BITS];
  logic [DEN_W-1:0]    d_r [OUT_BITS];
  logic [TW-1:0]       h_r [OUT_BITS];
  logic [OUT_BITS-1:0] r_r [OUT_BITS];

  for (genvar j = 0; j < OUT_BITS; j++) begin : g_bit
    localparam int K = OUT_BITS - 1 - j;
    logic [TW-1:0]       p_in;
    logic [TW-1:0]       h_in;
    logic [TW-1:0]       t_nxt;
    logic [QW-1:0]       q_in;
    logic [DEN_W-1:0]    d_in;
    logic [OUT_BITS-1:0] r_in;
    logic                take;

    if (j == 0) begin : g_first
      assign p_in = '0;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = den_i;
      assign h_in = TW'(num_i) << (2 * FRAC_BITS);
    end else begin : g_next
      assign p_in = p_r[j-1];
      assign q_in = q_r[j-1];
      assign r_in = r_r[j-1];
      assign d_in = d_r[j-1];
      assign h_in = h_r[j-1];
    end

    // (r + 2^K)^2 * den = r^2*den + 2^(K+1)*r*den + 2^(2K)*den
    assign t_nxt = p_in + (TW'(q_in) << (K + 1)) + (TW'(d_in) << (2 * K));
    assign take  = (t_nxt <= h_in);

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[j] <= take ? t_nxt : p_in;
        q_r[j] <= take ? (q_in + (QW'(d_in) << K)) : q_in;
        r_r[j] <= take ? (r_in | (OUT_BITS'(1) << K)) : r_in;
        d_r[j] <= d_in;
        h_r[j] <= h_in;
      end
    end
  end

  assign root_o = r_r[OUT_BITS-1];

endmodule

// ----- src/segment_pair_distance_2d.sv -----
// Channel | Dir | tdata (low bit first)                      | tuser
// in_     | in  | ax, ay, bx, by_coord, cx, cy, dx, dy        | -
// out_    | out | distance_q16 (33 bits), zero fill to bytes | touching
//
// One request enters per cycle while in_tready is high. The pipeline depth is set
// by the bit-per-stage square root, which resolves one of the 33 result bits
// in each stage, behind five front stages.
// Reset clears only the valid bits: the pipeline valid chain and the output and skid valid flags.
// A stalled output parks one extra result in a skid register; in_tready is
// low only while that register is occupied, and then the whole pipeline holds.
module segment_pair_distance_2d
  import spd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // ax, ay, bx, by_coord, cx, cy, dx, dy
  input  logic [((8*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // distance_q16
  output logic [((OUT_BITS+7)/8)*8-1:0]          out_tdata,
  // touching
  output logic                                   out_tuser
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int SW    = PW + 1;
  localparam int SQ_W  = 2 * CW;
  localparam int DEN_W = 2 * CW + 2;
  localparam int MAG_W = 2 * CW + 2;
  localparam int H     = (MAG_W + 1) / 2;
  localparam int HI_W  = MAG_W - H;
  localparam int NUM_W = 2 * MAG_W;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int NV    = 5 + OUT_BITS + 1;

  logic          en;
  logic [NV-1:0] v_r;
  logic          o_valid_r, s_valid_r, o_touch_r, s_touch_r;

  assign en        = !s_valid_r;
  assign in_tready = en;

  // Candidates: C and D against AB, then A and B against CD.
  logic [CW-1:0] pt [4][2];
  for (genvar i = 0; i < 4; i++) begin : g_pt
    assign pt[i][0] = in_tdata[(2*i)*CW +: CW];
    assign pt[i][1] = in_tdata[(2*i+1)*CW +: CW];
  end

  // Stage 1: differences.
  logic signed [DW-1:0] ux_r [4], uy_r [4], pax_r [4], pay_r [4], pbx_r [4], pby_r [4];
  // Stage 2: products.
  logic signed [PW-1:0] s1a_r [4], s1b_r [4], s2a_r [4], s2b_r [4], c1_r [4], c2_r [4];
  logic [SQ_W-1:0]      sqax_r [4], sqay_r [4], sqbx_r [4], sqby_r [4], squx_r [4], squy_r [4];
  logic                 within2_r [4], degen_r [4];
  // Stage 3: sums.
  logic                 perp3_r [4], cpos_r [4], cneg_r [4], within3_r [4];
  logic [MAG_W-1:0]     mag_r [4];
  logic [DEN_W-1:0]     dmin3_r [4], den3_r [4];
  // Stage 4: partial squares of the cross product.
  logic [2*HI_W-1:0]    hh_r [4];
  logic [HI_W+H-1:0]    hl_r [4];
  logic [2*H-1:0]       ll_r [4];
  logic                 perp4_r [4];
  logic [DEN_W-1:0]     dmin4_r [4], den4_r [4];
  logic                 touch4_r;
  // Stage 5: squared distance as num/den.
  logic [NUM_W-1:0]     num5_r [4];
  logic [DEN_W-1:0]     den5_r [4];
  logic                 touch5_r;
  logic [OUT_BITS-1:0]  root [4];

  function automatic logic signed [DW-1:0] diff(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
    return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
  endfunction

  for (genvar c = 0; c < 4; c++) begin : g_cand
    localparam int PI = (c < 2) ? c + 2 : c - 2;
    localparam int AI = (c < 2) ? 0 : 2;
    localparam int BI = AI + 1;
    logic signed [SW-1:0] s1, s2n, cr;
    logic [SW-1:0]        cr_abs;
    logic [DEN_W-1:0]     da, db;
    logic [HI_W-1:0]      m_hi;
    logic [H-1:0]         m_lo;
    logic [NUM_W-1:0]     sq_sum;

    always_ff @(posedge clk) begin
      if (en) begin
        ux_r[c]  <= diff(pt[BI][0], pt[AI][0]);
        uy_r[c]  <= diff(pt[BI][1], pt[AI][1]);
        pax_r[c] <= diff(pt[PI][0], pt[AI][0]);
        pay_r[c] <= diff(pt[PI][1], pt[AI][1]);
        pbx_r[c] <= diff(pt[PI][0], pt[BI][0]);
        pby_r[c] <= diff(pt[PI][1], pt[BI][1]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s1a_r[c]  <= pax_r[c] * ux_r[c];
        s1b_r[c]  <= pay_r[c] * uy_r[c];
        s2a_r[c]  <= pbx_r[c] * ux_r[c];
        s2b_r[c]  <= pby_r[c] * uy_r[c];
        c1_r[c]   <= ux_r[c] * pay_r[c];
        c2_r[c]   <= uy_r[c] * pax_r[c];
        sqax_r[c] <= SQ_W'(pax_r[c] * pax_r[c]);
        sqay_r[c] <= SQ_W'(pay_r[c] * pay_r[c]);
        sqbx_r[c] <= SQ_W'(pbx_r[c] * pbx_r[c]);
        sqby_r[c] <= SQ_W'(pby_r[c] * pby_r[c]);
        squx_r[c] <= SQ_W'(ux_r[c] * ux_r[c]);
        squy_r[c] <= SQ_W'(uy_r[c] * uy_r[c]);
        // P lies within the box of the segment when (p-a)(p-b) <= 0 on both axes.
        within2_r[c] <= ((pax_r[c] >= 0 && pbx_r[c] <= 0) || (pax_r[c] <= 0 && pbx_r[c] >= 0))
                     && ((pay_r[c] >= 0 && pby_r[c] <= 0) || (pay_r[c] <= 0 && pby_r[c] >= 0));
        degen_r[c]   <= (ux_r[c] == 0) && (uy_r[c] == 0);
      end
    end

    assign s1     = SW'(s1a_r[c]) + SW'(s1b_r[c]);
    assign s2n    = SW'(s2a_r[c]) + SW'(s2b_r[c]);
    assign cr     = SW'(c1_r[c]) - SW'(c2_r[c]);
    assign cr_abs = cr[SW-1] ? SW'(-cr) : SW'(cr);
    assign da     = DEN_W'(sqax_r[c]) + DEN_W'(sqay_r[c]);
    assign db     = DEN_W'(sqbx_r[c]) + DEN_W'(sqby_r[c]);

    always_ff @(posedge clk) begin
      if (en) begin
        perp3_r[c]   <= !degen_r[c] && !s1[SW-1] && (s2n[SW-1] || s2n == 0);
        cpos_r[c]    <= !cr[SW-1] && (cr != 0);
        cneg_r[c]    <= cr[SW-1];
        within3_r[c] <= within2_r[c];
        mag_r[c]     <= cr_abs[MAG_W-1:0];
        dmin3_r[c]   <= (da < db) ? da : db;
        den3_r[c]    <= DEN_W'(squx_r[c]) + DEN_W'(squy_r[c]);
      end
    end

    assign m_hi = mag_r[c][MAG_W-1:H];
    assign m_lo = mag_r[c][H-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        hh_r[c]    <= (2*HI_W)'(m_hi) * (2*HI_W)'(m_hi);
        hl_r[c]    <= (HI_W+H)'(m_hi) * (HI_W+H)'(m_lo);
        ll_r[c]    <= (2*H)'(m_lo) * (2*H)'(m_lo);
        perp4_r[c] <= perp3_r[c];
        dmin4_r[c] <= dmin3_r[c];
        den4_r[c]  <= den3_r[c];
      end
    end

    assign sq_sum = (NUM_W'(hh_r[c]) << (2 * H)) + (NUM_W'(hl_r[c]) << (H + 1))
                  + NUM_W'(ll_r[c]);

    // A touching pair gets a zero numerator, which makes its root zero.
    always_ff @(posedge clk) begin
      if (en) begin
        if (touch4_r) begin
          num5_r[c] <= '0;
        end else if (perp4_r[c]) begin
          num5_r[c] <= sq_sum;
        end else begin
          num5_r[c] <= NUM_W'(dmin4_r[c]);
        end
        den5_r[c] <= perp4_r[c] ? den4_r[c] : DEN_W'(1);
      end
    end

    spd_root #(
      .NUM_W    (NUM_W),
      .DEN_W    (DEN_W),
      .FRAC_BITS(FRAC_BITS)
    ) u_root (
      .clk   (clk),
      .en    (en),
      .num_i (num5_r[c]),
      .den_i (den5_r[c]),
      .root_o(root[c])
    );
  end

  logic touch_nxt;
  always_comb begin
    touch_nxt = (((cpos_r[0] && cneg_r[1]) || (cneg_r[0] && cpos_r[1]))
              && ((cpos_r[2] && cneg_r[3]) || (cneg_r[2] && cpos_r[3])));
    for (int i = 0; i < 4; i++) begin
      if (!cpos_r[i] && !cneg_r[i] && within3_r[i]) begin
        touch_nxt = 1'b1;
      end
    end
  end

  logic                touch_pipe_r [OUT_BITS];
  logic [OUT_BITS-1:0] ma_r, mb_r;
  logic                tm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      touch4_r        <= touch_nxt;
      touch5_r        <= touch4_r;
      touch_pipe_r[0] <= touch5_r;
      for (int i = 1; i < OUT_BITS; i++) begin
        touch_pipe_r[i] <= touch_pipe_r[i-1];
      end
      ma_r <= (root[0] < root[1]) ? root[0] : root[1];
      mb_r <= (root[2] < root[3]) ? root[2] : root[3];
      tm_r <= touch_pipe_r[OUT_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NV-2:0], in_tvalid};
    end
  end

  // Output register with one skid entry behind it.
  logic [OUT_BITS-1:0] fin;
  logic                push;
  logic [OUT_BITS-1:0] o_dist_r, s_dist_r;

  assign fin  = (ma_r < mb_r) ? ma_r : mb_r;
  assign push = en && v_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else if (s_valid_r) begin
      if (out_tready) begin
        o_dist_r  <= s_dist_r;
        o_touch_r <= s_touch_r;
        s_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!o_valid_r || out_tready) begin
        o_dist_r  <= fin;
        o_touch_r <= tm_r;
        o_valid_r <= 1'b1;
      end else begin
        s_dist_r  <= fin;
        s_touch_r <= tm_r;
        s_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      o_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = OUT_W'(o_dist_r);
  assign out_tuser  = o_touch_r;

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import spd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int DW = ((OUT_BITS + 7) / 8) * 8;
  localparam int IW = ((8 * CB + 7) / 8) * 8;
  localparam int WATCHDOG = 20000;
  localparam int LATENCY = 39;

  typedef struct packed {
    logic signed [CB-1:0] dy, dx, cy, cx, by_coord, bx, ay, ax;
  } seg_pair_t;

  typedef struct {
    logic [OUT_BITS-1:0] distance;
    logic                touch;
  } dist_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DW-1:0] out_tdata;
  logic out_tuser;

  seg_pair_t    pending_q[$];
  dist_result_t expected_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 19;
  int  recv_idle_pct = 57;
  bit  hold_sender = 1'b0;
  bit  in_taken = 1'b0;

  segment_pair_distance_2d i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint orient(longint ax, longint ay, longint bx, longint by,
                                    longint px, longint py);
    longint cr;
    cr = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    return (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
  endfunction

  function automatic bit on_box(longint px, longint py, longint ax, longint ay,
                                longint bx, longint by);
    return px >= ((ax < bx) ? ax : bx) && px <= ((ax < bx) ? bx : ax) &&
           py >= ((ay < by) ? ay : by) && py <= ((ay < by) ? by : ay);
  endfunction

  // Squared distance from p to segment ab as num/den.
  function automatic void point_to_seg(longint px, longint py, longint ax, longint ay,
                                       longint bx, longint by,
                                       output logic [255:0] num,
                                       output logic [255:0] den);
    longint ux, uy, s1, s2, cr, da, db;
    ux = bx - ax;
    uy = by - ay;
    s1 = (px - ax) * ux + (py - ay) * uy;
    s2 = (bx - px) * ux + (by - py) * uy;
    if ((ux != 0 || uy != 0) && s1 >= 0 && s2 >= 0) begin
      cr = ux * (py - ay) - uy * (px - ax);
      if (cr < 0) cr = -cr;
      num = 256'(cr) * 256'(cr);
      den = 256'(ux * ux + uy * uy);
    end else begin
      da = (px - ax) * (px - ax) + (py - ay) * (py - ay);
      db = (px - bx) * (px - bx) + (py - by) * (py - by);
      num = 256'((da < db) ? da : db);
      den = 256'd1;
    end
  endfunction

  function automatic dist_result_t predict_distance(seg_pair_t s);
    dist_result_t r;
    longint p[8];
    longint o1, o2, o3, o4;
    logic [255:0] bn, bd, n, d, rhs, m;
    logic [63:0] lo, hi, mid;
    p[0] = s.ax; p[1] = s.ay; p[2] = s.bx; p[3] = s.by_coord;
    p[4] = s.cx; p[5] = s.cy; p[6] = s.dx; p[7] = s.dy;
    o1 = orient(p[0], p[1], p[2], p[3], p[4], p[5]);
    o2 = orient(p[0], p[1], p[2], p[3], p[6], p[7]);
    o3 = orient(p[4], p[5], p[6], p[7], p[0], p[1]);
    o4 = orient(p[4], p[5], p[6], p[7], p[2], p[3]);
    r.touch = (o1 * o2 < 0 && o3 * o4 < 0)
           || (o1 == 0 && on_box(p[4], p[5], p[0], p[1], p[2], p[3]))
           || (o2 == 0 && on_box(p[6], p[7], p[0], p[1], p[2], p[3]))
           || (o3 == 0 && on_box(p[0], p[1], p[4], p[5], p[6], p[7]))
           || (o4 == 0 && on_box(p[2], p[3], p[4], p[5], p[6], p[7]));
    r.distance = '0;
    if (!r.touch) begin
      point_to_seg(p[4], p[5], p[0], p[1], p[2], p[3], bn, bd);
      for (int k = 1; k < 4; k++) begin
        if (k == 1) point_to_seg(p[6], p[7], p[0], p[1], p[2], p[3], n, d);
        else point_to_seg(p[2*k-4], p[2*k-3], p[4], p[5], p[6], p[7], n, d);
        if (n * bd < bn * d) begin
          bn = n;
          bd = d;
        end
      end
      rhs = bn << (2 * FB);
      lo = 0;
      hi = (64'd1 << OUT_BITS) - 1;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        m = 256'(mid);
        if (m * m * bd <= rhs) lo = mid;
        else hi = mid - 1;
      end
      r.distance = lo[OUT_BITS-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($urandom_range(0, 40) - 20);
      default: return CB'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
    endcase
  endfunction

  task automatic add_pair(int a0, int a1, int b0, int b1, int c0, int c1, int d0, int d1);
    seg_pair_t s;
    s.ax = CB'(a0); s.ay = CB'(a1); s.bx = CB'(b0); s.by_coord = CB'(b1);
    s.cx = CB'(c0); s.cy = CB'(c1); s.dx = CB'(d0); s.dy = CB'(d1);
    pending_q.push_back(s);
  endtask

  // Driver: one request per cycle at most, changed on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        // Request still waiting; keep it.
      end else if (pending_q.size() > 0 && !hold_sender &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_tdata <= IW'(pending_q[0]);
        in_tvalid <= 1'b1;
        pending_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: prediction on accepted requests, checking on accepted results.
  always @(posedge clk) begin
    dist_result_t w;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_distance(seg_pair_t'(in_tdata[8*CB-1:0])));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_tdata), 64'd0);
        end else begin
          w = expected_q.pop_front();
          if (out_tdata[OUT_BITS-1:0] !== w.distance)
            report_mismatch("distance_q16", 64'(out_tdata[OUT_BITS-1:0]), 64'(w.distance));
          if (out_tdata[DW-1:OUT_BITS] !== '0)
            report_mismatch("tdata fill", 64'(out_tdata[DW-1:OUT_BITS]), 64'd0);
          if (out_tuser !== w.touch)
            report_mismatch("touching", 64'(out_tuser), 64'(w.touch));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("FAIL segment_pair_distance_2d");
        $finish;
      end
    end
  end

  initial begin
    seg_pair_t s;
    int mode;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Crossing, collinear overlap, collinear apart, touching ends, degenerate.
    add_pair(0, 0, 10, 10, 0, 10, 10, 0);
    add_pair(0, 0, 10, 0, 5, 0, 20, 0);
    add_pair(0, 0, 10, 0, 13, 0, 20, 0);
    add_pair(0, 0, 10, 0, 10, 0, 10, 7);
    add_pair(3, 3, 3, 3, 3, 3, 3, 3);
    add_pair(3, 3, 3, 3, 7, 6, 7, 6);
    add_pair(0, 0, 0, 0, -5, 2, 5, 2);
    add_pair(0, 0, 10, 0, 5, 3, 5, 9);
    add_pair(0, 0, 10, 0, 12, 3, 20, 9);
    add_pair(0, 0, 1, 1, 0, 1, 1, 2);
    add_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
    add_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
    add_pair(32767, -32768, -32768, 32767, 32767, 32767, 32767, 32767);
    add_pair(-32768, 32767, -32768, -32768, 32767, -32768, 32767, 32767);
    add_pair(-1, -1, -1, -1, 0, 0, 0, 0);
    add_pair(0, 0, 65535, 0, 0, 65535, 0, 0);
    add_pair(1, 2, 4, 8, 16, 32, 64, 128);
    add_pair(-2, -3, -5, -9, -17, -33, -65, -129);

    for (int i = 0; i < 500; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        s = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
      end else if (mode < 8) begin
        s.ax = rand_coord(1); s.ay = rand_coord(1); s.bx = rand_coord(1);
        s.by_coord = rand_coord(1); s.cx = rand_coord(1); s.cy = rand_coord(1);
        s.dx = rand_coord(1); s.dy = rand_coord(1);
      end else if (mode == 8) begin
        // Collinear pieces on one line through A with a shared direction.
        s.ax = rand_coord(1); s.ay = rand_coord(1);
        s.bx = s.ax + CB'(2); s.by_coord = s.ay + CB'(1);
        s.cx = s.ax + CB'(2 * ($urandom_range(0, 6) - 2));
        s.cy = s.ay + CB'($signed(s.cx - s.ax) / 2);
        s.dx = s.cx + CB'(2); s.dy = s.cy + CB'(1);
      end else begin
        s.ax = rand_coord(2); s.ay = rand_coord(2); s.bx = rand_coord(2);
        s.by_coord = rand_coord(2); s.cx = rand_coord(2); s.cy = rand_coord(0);
        s.dx = rand_coord(2); s.dy = rand_coord(0);
      end
      pending_q.push_back(s);
      if (i == 170) begin
        // Let the pipeline drain completely before going on.
        wait (pending_q.size() == 0);
        hold_sender = 1'b1;
        wait (expected_q.size() == 0 && !in_tvalid);
        hold_sender = 1'b0;
        send_idle_pct = 57;
        recv_idle_pct = 19;
      end else if (i == 340) begin
        wait (pending_q.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    wait (pending_q.size() == 0);
    @(posedge clk);
    wait (!in_tvalid && expected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS segment_pair_distance_2d");
    end else begin
      $display("FAIL segment_pair_distance_2d");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/spd_pkg.sv
src/spd_root.sv
src/segment_pair_distance_2d.sv
tb/sv/tb.sv
